FILE: hw/rtl/oile_pkg.sv
// Shared types and constants for the ordered integer list engine.
// No dependencies; used by every module of the block but oile_ram.
`default_nettype none

package oile_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DEL_POS = 3'd2;
  localparam logic [2:0] OP_DEL_KEY = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_FIND    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [8:0]         item_count;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ordered_int_list_engine_unit.sv
// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_ready   op, item_value, position
// out_      output     out_valid / out_ready status, read_value, found_position, item_count
//
// Top level of the ordered integer list engine; depends on oile_pkg, oile_ram,
// oile_seq and oile_obuf.
// One request is worked at a time; the entry memory has one read and one write port
// and the sequencer moves one entry per cycle. Append and rejected requests go straight to
// the response; read waits for its data; insert at p shifts the entries from p up and then
// writes p; delete at p shifts the entries above p down; find and delete by key scan from
// entry 0, a delete then shifting. Reset clears the state and the count; the memory needs
// no clearing. A new request is taken while the last result waits in the output register.
`default_nettype none

module ordered_int_list_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic [8:0]         in_position,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         out_status,
  output      logic signed [31:0] out_read_value,
  output      logic [7:0]         out_found_position,
  output      logic [8:0]         out_item_count
);

  oile_pkg::mem_req_t          mem_req;
  logic [oile_pkg::DATA_W-1:0] rdata;
  logic                        res_valid;
  logic                        res_ready;
  oile_pkg::res_t              res;
  oile_pkg::res_t              out_res;

  oile_ram #(
    .DEPTH (oile_pkg::CAPACITY),
    .WIDTH (oile_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  oile_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .mem_req       (mem_req),
    .rdata         (rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  oile_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_read_value     = out_res.read_value;
  assign out_found_position = out_res.found_position;
  assign out_item_count     = out_res.item_count;

endmodule

`default_nettype wire

FILE: hw/rtl/oile_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module oile_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/oile_seq.sv
// Sequencer of the list engine: decodes a request, walks and shifts the entry memory.
// Depends on oile_pkg; drives the entry memory through a mem_req_t.
`default_nettype none

module oile_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [2:0]                  in_op,
  input  wire logic signed [31:0]          in_item_value,
  input  wire logic [8:0]                  in_position,
  output      oile_pkg::mem_req_t          mem_req,
  input  wire logic [oile_pkg::DATA_W-1:0] rdata,
  output      logic                        res_valid,
  input  wire logic                        res_ready,
  output      oile_pkg::res_t              res
);

  localparam int AW = oile_pkg::ADDR_W;
  localparam int CW = oile_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(oile_pkg::CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SHIFT_UP = 7'b0000010,
    S_PUT      = 7'b0000100,
    S_SHIFT_DN = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_RDWAIT   = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [31:0]   rd_r, rd_nxt;
  logic [AW-1:0] fp_r, fp_nxt;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_ext;

  assign count_m1 = count_r - CW'(1);
  assign idx_ext  = {1'b0, idx_r};
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    fp_nxt        = fp_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = rdata;
    mem_req.raddr = idx_r;
    res_valid     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          val_nxt   = in_item_value;
          pos_nxt   = in_position[AW-1:0];
          rd_nxt    = '0;
          fp_nxt    = '0;
          st_nxt    = oile_pkg::ST_OK;
          state_nxt = S_RESP;
          unique case (in_op) inside
            oile_pkg::OP_APPEND: begin
              if (count_r >= CAP_CNT) begin
                st_nxt = oile_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_r[AW-1:0];
                mem_req.wdata = in_item_value;
                count_nxt     = count_r + CW'(1);
              end
            end
            oile_pkg::OP_INSERT: begin
              if (in_position > count_r) begin
                st_nxt = oile_pkg::ST_BAD;
              end else if (count_r >= CAP_CNT) begin
                st_nxt = oile_pkg::ST_FULL;
              end else if (in_position == count_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_r[AW-1:0];
                mem_req.wdata = in_item_value;
                count_nxt     = count_r + CW'(1);
              end else begin
                idx_nxt       = count_m1[AW-1:0];
                mem_req.raddr = count_m1[AW-1:0];
                state_nxt     = S_SHIFT_UP;
              end
            end
            oile_pkg::OP_DEL_POS: begin
              if (in_position >= count_r) begin
                st_nxt = oile_pkg::ST_BAD;
              end else if (in_position == count_m1) begin
                count_nxt = count_m1;
              end else begin
                idx_nxt       = in_position[AW-1:0];
                mem_req.raddr = in_position[AW-1:0] + AW'(1);
                state_nxt     = S_SHIFT_DN;
              end
            end
            oile_pkg::OP_DEL_KEY, oile_pkg::OP_FIND: begin
              if (count_r == '0) begin
                st_nxt = oile_pkg::ST_BAD;
              end else begin
                idx_nxt       = '0;
                mem_req.raddr = '0;
                state_nxt     = S_SCAN;
              end
            end
            oile_pkg::OP_READ: begin
              if (in_position >= count_r) begin
                st_nxt = oile_pkg::ST_BAD;
              end else begin
                mem_req.raddr = in_position[AW-1:0];
                state_nxt     = S_RDWAIT;
              end
            end
            default: begin
              st_nxt = oile_pkg::ST_BAD;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r + AW'(1);
        mem_req.wdata = rdata;
        mem_req.raddr = idx_r - AW'(1);
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = val_r;
        count_nxt     = count_r + CW'(1);
        state_nxt     = S_RESP;
      end
      S_SHIFT_DN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = rdata;
        mem_req.raddr = idx_r + AW'(2);
        if (idx_ext + CW'(2) == count_r) begin
          count_nxt = count_m1;
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_SCAN: begin
        // The read of the next entry is always issued, so a delete can
        // continue straight into the shift.
        mem_req.raddr = idx_r + AW'(1);
        if (rdata == val_r) begin
          if (op_r == oile_pkg::OP_FIND) begin
            fp_nxt    = idx_r;
            state_nxt = S_RESP;
          end else if (idx_ext + CW'(1) == count_r) begin
            count_nxt = count_m1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SHIFT_DN;
          end
        end else if (idx_ext + CW'(1) == count_r) begin
          st_nxt    = oile_pkg::ST_BAD;
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_RDWAIT: begin
        rd_nxt    = rdata;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r  <= op_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    st_r  <= st_nxt;
    rd_r  <= rd_nxt;
    fp_r  <= fp_nxt;
  end

  assign res.status         = st_r;
  assign res.read_value     = rd_r;
  assign res.found_position = 8'(fp_r);
  assign res.item_count     = 9'(count_r);

endmodule

`default_nettype wire

FILE: hw/rtl/oile_obuf.sv
// Output register of the list engine: holds one result word until it is taken.
// Depends on oile_pkg for the result type.
`default_nettype none

module oile_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_valid,
  output      logic           res_ready,
  input  wire oile_pkg::res_t res,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      oile_pkg::res_t out_res
);

  logic           out_valid_r, out_valid_nxt;
  oile_pkg::res_t out_res_r, out_res_nxt;

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

FILE: hw/rtl/oile_chk.sv
// Port-level checker for the ordered integer list engine, bound to the top level.
// Depends on oile_pkg for status codes and capacity.
`default_nettype none

module oile_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_read_value,
  input wire logic [7:0]         out_found_position,
  input wire logic [8:0]         out_item_count
);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_count <= 9'(oile_pkg::CAPACITY))
    else $error("item count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == oile_pkg::ST_FULL |-> out_item_count == 9'(oile_pkg::CAPACITY))
    else $error("full status with a list that is not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != oile_pkg::ST_OK |-> out_read_value == 0 && out_found_position == 0)
    else $error("failed request returned data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before the first finished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_count) && $stable(out_status))
    else $error("result word changed while stalled");

endmodule

bind ordered_int_list_engine_unit oile_chk u_chk (.*);

`default_nettype wire
